/* rtl/hrrn_pkg.sv */
`timescale 1ns / 1ps
package hrrn_pkg;
  localparam int NUM_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam logic [1:0] REQ_ENQ = 2'd0;
  localparam logic [1:0] REQ_DISP = 2'd1;
  localparam logic [1:0] REQ_BEND = 2'd2;
  localparam logic [1:0] REQ_EXIT = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;
  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_INIT_EST = 2'd1;
  localparam logic [1:0] REG_ALPHA = 2'd2;
  localparam logic [15:0] INIT_EST_RST = 16'd10000;
  localparam logic [8:0] ALPHA_RST = 9'd128;
endpackage

/* rtl/hrrn_if.sv */
`timescale 1ns / 1ps
interface hrrn_req_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [15:0] proc_id;
  logic [31:0] now_time;
  modport source (output valid, req_type, proc_id, now_time, input ready);
  modport sink (input valid, req_type, proc_id, now_time, output ready);
endinterface

interface hrrn_rsp_if;
  logic valid;
  logic ready;
  logic [15:0] chosen_id;
  logic [15:0] new_estimate;
  logic [1:0] status;
  modport source (output valid, chosen_id, new_estimate, status, input ready);
  modport sink (input valid, chosen_id, new_estimate, status, output ready);
endinterface

/* rtl/hrrn_ram.sv */
`timescale 1ns / 1ps
module hrrn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/hrrn_ready_scheduler.sv */
`timescale 1ns / 1ps
// Scheduler over NUM_SLOTS process slots. Pid, ready time, estimate and
// execution start live in one synchronous RAM; valid and ready marks are
// flip-flops. Each request walks the RAM one slot a cycle (the RAM read is
// registered) unless a highest ratio dispatch holds the scan. Requests that
// rewrite their entry (enqueue of a waiting id, dispatch, burst end) then
// read it back in S_RD and write it in S_WR. In highest ratio mode every
// ready slot after the first holds the scan in S_MUL1 and S_MUL2 for its two
// TIME_BITSx16 cross products. One request is in flight at a time; the
// result waits in an output register and the next request is taken the
// cycle after it has left.
module hrrn_ready_scheduler
  import hrrn_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hrrn_req_if.sink    req,
  hrrn_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW = $clog2(NUM_SLOTS);
  localparam int TB = TIME_BITS;
  localparam int EW = 32 + 2 * TB;
  localparam int PW = TB + 16;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_SCAN = 7'b0000010, S_MUL1 = 7'b0000100,
    S_MUL2 = 7'b0001000, S_DONE = 7'b0010000, S_RD = 7'b0100000,
    S_WR = 7'b1000000
  } state_t;

  state_t state;
  logic policy;
  logic [15:0] init_est;
  logic [8:0] alpha;
  logic [NUM_SLOTS-1:0] vld, rdy;
  logic [1:0] r_type;
  logic [15:0] r_pid;
  logic [TB-1:0] r_now;
  logic [AW:0] idx;
  logic [AW-1:0] hit, freei, best;
  logic hit_f, free_f, best_f;
  logic [TB-1:0] bw, cw;
  logic [15:0] best_est, best_pid, cest, cpid;
  logic [PW-1:0] pa, pb;
  logic [AW-1:0] cand;
  logic [15:0] mest;
  logic [TB-1:0] mtime;
  logic [15:0] o_id, o_est;
  logic [1:0] o_st;
  logic o_v;
  logic rmw;
  logic [1:0] d_st;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  hrrn_ram #(.WIDTH(EW), .DEPTH(NUM_SLOTS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );
  // entry layout: pid, ready_since, estimate, exec_start
  logic [15:0] e_pid, e_est;
  logic [TB-1:0] e_rs, e_xs;
  assign e_pid = rdata[EW-1 -: 16];
  assign e_rs = rdata[EW-17 -: TB];
  assign e_est = rdata[TB+15 -: 16];
  assign e_xs = rdata[TB-1:0];

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_POLICY: prdata[0] = policy;
      REG_INIT_EST: prdata[15:0] = init_est;
      REG_ALPHA: prdata[8:0] = alpha;
      default: prdata = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= 1'b1; init_est <= INIT_EST_RST; alpha <= ALPHA_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_POLICY: policy <= pwdata[0];
        REG_INIT_EST: init_est <= pwdata[15:0];
        REG_ALPHA: alpha <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE) && !o_v;
  assign rsp.valid = o_v;
  assign rsp.chosen_id = o_id;
  assign rsp.new_estimate = o_est;
  assign rsp.status = o_st;

  logic [AW-1:0] pi;
  logic [TB-1:0] w_i;
  logic [TB+24:0] d_full;
  logic [24:0] dcl;
  logic [8:0] a_eff;
  logic [41:0] v_sum;
  logic [33:0] v_sh;
  assign pi = AW'(idx - 1'b1);
  assign w_i = r_now - e_rs;
  assign raddr = (state == S_RD || state == S_WR) ? hit : idx[AW-1:0];
  assign a_eff = (alpha > 9'd256) ? 9'd256 : alpha;
  assign pb = PW'(mtime) * PW'(mest);
  always_comb begin
    d_full = {25'd0, r_now - e_xs};
    dcl = (d_full > (TB+25)'(1 << 24)) ? 25'(1 << 24) : 25'(d_full);
    v_sum = 42'(a_eff) * 42'(e_est) + 42'(9'd256 - a_eff) * 42'(dcl);
    v_sh = 34'(v_sum >> 8);
  end

  // outcome of the scan: status, and whether the entry needs a read back
  always_comb begin
    rmw = 1'b0; d_st = ST_OK;
    unique case (r_type)
      REQ_ENQ: if (hit_f) rmw = !rdy[hit];
        else if (!free_f) d_st = ST_FULL;
      REQ_DISP: if (best_f) rmw = 1'b1;
        else d_st = ST_EMPTY;
      REQ_BEND: if (hit_f) rmw = 1'b1;
        else d_st = ST_UNKNOWN;
      REQ_EXIT: if (!hit_f) d_st = ST_UNKNOWN;
      default: ;
    endcase
  end

  always_comb begin
    we = 1'b0; waddr = hit; wdata = rdata;
    if (state == S_DONE && r_type == REQ_ENQ && !hit_f && free_f) begin
      we = 1'b1; waddr = freei; wdata = {r_pid, r_now, init_est, r_now};
    end else if (state == S_WR) begin
      we = 1'b1; waddr = hit;
      if (r_type == REQ_ENQ) wdata = {e_pid, r_now, e_est, e_xs};
      else if (r_type == REQ_DISP) wdata = {e_pid, e_rs, e_est, r_now};
      else wdata = {e_pid, e_rs, (v_sh > 34'd65535) ? 16'hFFFF : v_sh[15:0], e_xs};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; vld <= '0; rdy <= '0; o_v <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) o_v <= 1'b0;
      unique case (state)
        S_IDLE: if (req.valid && req.ready) begin
          r_type <= req.req_type; r_pid <= req.proc_id;
          r_now <= TB'(req.now_time);
          idx <= '0; hit_f <= 1'b0; free_f <= 1'b0; best_f <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // data for slot idx-1 is on the RAM output
          if (idx != '0) begin
            if (vld[pi] && e_pid == r_pid && !hit_f) begin
              hit_f <= 1'b1; hit <= pi;
            end
            if (!vld[pi] && !free_f) begin
              free_f <= 1'b1; freei <= pi;
            end
          end
          if (r_type == REQ_DISP && idx != '0 && vld[pi] && rdy[pi]) begin
            cand <= pi; cw <= w_i; cest <= e_est; cpid <= e_pid;
            if (!best_f || !policy) begin
              if (!best_f || w_i > bw) begin
                best_f <= 1'b1; best <= pi; bw <= w_i;
                best_est <= e_est; best_pid <= e_pid;
              end
              if (idx == (AW+1)'(NUM_SLOTS)) state <= S_DONE;
              else idx <= idx + 1'b1;
            end else begin
              mest <= best_est; mtime <= w_i;
              state <= S_MUL1;
            end
          end else if (idx == (AW+1)'(NUM_SLOTS)) state <= S_DONE;
          else idx <= idx + 1'b1;
        end
        S_MUL1: begin
          pa <= PW'(mtime) * PW'(mest);
          mtime <= bw; mest <= cest;
          state <= S_MUL2;
        end
        S_MUL2: begin
          if (pa > pb || (pa == pb && cw > bw)) begin
            best <= cand; bw <= cw; best_est <= cest; best_pid <= cpid;
          end
          if (idx == (AW+1)'(NUM_SLOTS)) state <= S_DONE;
          else begin idx <= idx + 1'b1; state <= S_SCAN; end
        end
        S_DONE: begin
          o_v <= !rmw;
          o_id <= (r_type == REQ_DISP && best_f) ? best_pid : r_pid;
          o_est <= (r_type == REQ_DISP && best_f) ? best_est : '0;
          o_st <= d_st;
          state <= rmw ? S_RD : S_IDLE;
          unique case (r_type)
            REQ_ENQ: if (hit_f) begin
              if (!rdy[hit]) rdy[hit] <= 1'b1;
            end else if (free_f) begin
              vld[freei] <= 1'b1; rdy[freei] <= 1'b1;
            end
            REQ_DISP: if (best_f) begin
              rdy[best] <= 1'b0; hit <= best;
            end
            REQ_EXIT: if (hit_f) begin
              vld[hit] <= 1'b0; rdy[hit] <= 1'b0;
            end
            default: ;
          endcase
        end
        S_RD: state <= S_WR;
        S_WR: begin
          o_v <= 1'b1;
          if (r_type == REQ_BEND)
            o_est <= (v_sh > 34'd65535) ? 16'hFFFF : v_sh[15:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
